// ===== rtl/terp_pkg.sv =====
// package for the typed event ring with selective pop
// holds the action codes, field widths and sequencer state type; no dependencies
`default_nettype none

package terp_pkg;

    // fixed field widths of the ports
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned TYPE_W    = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned OCC_W     = 4;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // event type that means no event
    localparam logic [TYPE_W-1:0] TYPE_NONE = 4'd0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_CLOSE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/terp_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module terp_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/typed_event_ring_selective_pop_unit.sv =====
// top level of the typed event ring with selective pop
// uses terp_pkg for codes and states and terp_ram for the entry store
`default_nettype none

// Ring of DEPTH typed events held in one ram (type code and payload per entry).
// A push of a non-none type writes after the newest entry and overwrites the oldest
// when full, counting overwrites with saturation. A pop scans from the oldest entry for
// the requested type, returns its payload and moves every later entry one place down; a
// query only scans. One word is worked on at a time and o_ready is low while it is.
// Entries are read one at a time over the single ram read port and its registered
// read, so each compare or shift write state follows its own read state.
// The result sits in an output register, so the next word is taken while it waits.
// The store needs no clearing pass: only held entries are read.
module typed_event_ring_selective_pop_unit #(
    parameter int unsigned DEPTH         = 8,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [terp_pkg::ACTION_W-1:0]       i_action,
    input  wire logic [terp_pkg::TYPE_W-1:0]         i_event_type,
    input  wire logic [terp_pkg::WORD_W-1:0]         i_payload,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_found,
    output logic      [terp_pkg::WORD_W-1:0]         o_payload_out,
    output logic      [terp_pkg::OCC_W-1:0]          o_occupancy,
    output logic      [terp_pkg::WORD_W-1:0]         o_overflow_count
);

    import terp_pkg::*;

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned SW  = CW + 1;
    localparam int unsigned EW  = TYPE_W + PAYLOAD_WIDTH;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // sequencer and ring state
    t_state              r_state, n_state;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [TYPE_W-1:0]   r_kind, n_kind;
    logic [WORD_W-1:0]   r_data, n_data;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [WORD_W-1:0]   r_total, n_total;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_found, n_found;
    logic [WORD_W-1:0]   r_res, n_res;

    // output register
    logic                r_o_valid, n_o_valid;
    logic                r_o_found, n_o_found;
    logic [WORD_W-1:0]   r_o_payload, n_o_payload;
    logic [OCC_W-1:0]    r_o_occ, n_o_occ;
    logic [WORD_W-1:0]   r_o_ovf, n_o_ovf;

    // shared slot unit and ram ports
    logic [CW-1:0]       w_offset;
    logic [SW-1:0]       w_sum;
    logic [SW-1:0]       w_wrap;
    logic [AW-1:0]       w_slot;
    logic [SW-1:0]       w_idx_p1;
    logic [SW-1:0]       w_idx_p2;
    logic                ram_we;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;
    logic [TYPE_W-1:0]   w_rd_type;
    logic [WORD_W-1:0]   w_rd_word;

    terp_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_slot),
        .i_wdata (ram_wdata),
        .i_raddr (w_slot),
        .o_rdata (ram_rdata)
    );

    assign w_rd_type = ram_rdata[EW-1 -: TYPE_W];
    assign w_rd_word = WORD_W'(ram_rdata[PAYLOAD_WIDTH-1:0]);
    assign w_idx_p1  = SW'(r_idx) + SW'(1);
    assign w_idx_p2  = SW'(r_idx) + SW'(2);

    // offset select for the shared slot unit
    always_comb begin
        unique case (r_state)
            ST_PUSH:     w_offset = r_count;
            ST_SHIFT_RD: w_offset = w_idx_p1[CW-1:0];
            default:     w_offset = r_idx;
        endcase
    end

    // slot = (head + offset) mod depth, offset never above depth
    assign w_sum  = SW'(r_head) + SW'(w_offset);
    assign w_wrap = (w_sum >= DEPTH_S) ? (w_sum - DEPTH_S) : w_sum;
    assign w_slot = w_wrap[AW-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_kind      <= n_kind;
        r_data      <= n_data;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_res       <= n_res;
        r_o_found   <= n_o_found;
        r_o_payload <= n_o_payload;
        r_o_occ     <= n_o_occ;
        r_o_ovf     <= n_o_ovf;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_kind      = r_kind;
        n_data      = r_data;
        n_head      = r_head;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_found     = r_found;
        n_res       = r_res;
        n_o_valid   = r_o_valid & ~i_ready;
        n_o_found   = r_o_found;
        n_o_payload = r_o_payload;
        n_o_occ     = r_o_occ;
        n_o_ovf     = r_o_ovf;
        ram_we      = 1'b0;
        ram_wdata   = ram_rdata;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_act   = i_action;
                    n_kind  = i_event_type;
                    n_data  = i_payload;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_res   = '0;
                    if (i_action == ACT_PUSH && i_event_type != TYPE_NONE) begin
                        n_state = ST_PUSH;
                    end else if ((i_action == ACT_POP || i_action == ACT_QUERY)
                                 && r_count != '0) begin
                        n_state = ST_SCAN_RD;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_PUSH: begin
                // write after the newest entry, drop the oldest when full
                ram_we    = 1'b1;
                ram_wdata = {r_kind, PAYLOAD_WIDTH'(r_data)};
                if (SW'(r_count) < DEPTH_S) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_head = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                    if (r_total != '1) begin
                        n_total = r_total + WORD_W'(1);
                    end
                end
                n_state = ST_FINISH;
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                // ram data is the entry at offset idx
                if (w_rd_type == r_kind) begin
                    n_found = 1'b1;
                    if (r_act == ACT_POP) begin
                        n_res = w_rd_word;
                        if (w_idx_p1 < SW'(r_count)) begin
                            n_state = ST_SHIFT_RD;
                        end else begin
                            n_state = ST_CLOSE;
                        end
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (w_idx_p1 < SW'(r_count)) begin
                    n_idx   = w_idx_p1[CW-1:0];
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SHIFT_RD: begin
                n_state = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                // move the entry at idx+1 down to idx
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = w_idx_p1[CW-1:0];
                if (w_idx_p2 < SW'(r_count)) begin
                    n_state = ST_SHIFT_RD;
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                // one entry removed, head back to slot zero once empty
                n_count = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_head = '0;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_found   = r_found;
                    n_o_payload = r_res;
                    n_o_occ     = OCC_W'(r_count);
                    n_o_ovf     = r_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_found          = r_o_found;
    assign o_payload_out    = r_o_payload;
    assign o_occupancy      = r_o_occ;
    assign o_overflow_count = r_o_ovf;

`ifndef ASSERT_OFF
    // occupancy never exceeds the ring depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_count) <= DEPTH_S)
        else $error("held count above depth");

    // an empty ring always has its head at slot zero
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0))
        else $error("empty ring with nonzero head");

    // the store is written only by a push or a shift step
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_PUSH || r_state == ST_SHIFT_WR))
        else $error("store written outside push or shift");

    // a scan compare only looks at held entries
    a_scan_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CMP || r_state == ST_SHIFT_WR) |-> (r_idx < r_count))
        else $error("scan index beyond held entries");

    // the overwrite count never goes down outside reset
    a_total_mono: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_total >= $past(r_total)))
        else $error("overwrite count decreased");
`endif

endmodule

`default_nettype wire

// ===== tb/typed_event_ring_selective_pop_unit_test.sv =====
// testbench for the typed event ring with selective pop: directed and random words
// checked against a ring tracker; depends on terp_pkg and typed_event_ring_selective_pop_unit
`timescale 1ns / 100ps

module typed_event_ring_selective_pop_unit_test;

    import terp_pkg::*;

    localparam int unsigned RING_DEPTH   = 8;
    localparam int unsigned WORD_BITS    = 32;
    localparam int unsigned RANDOM_WORDS = 850;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic              found;
        logic [WORD_W-1:0] payload;
        logic [OCC_W-1:0]  occupancy;
        logic [WORD_W-1:0] overflow;
    } t_ring_result;

    // tracks ring contents and holds the results still owed by the block
    class event_ring_tracker;
        logic [TYPE_W-1:0] slot_type [RING_DEPTH];
        logic [WORD_W-1:0] slot_word [RING_DEPTH];
        int unsigned       head;
        int unsigned       held;
        logic [WORD_W-1:0] overwrites;
        t_ring_result      owed_results [$];
        int unsigned       failures;

        function new();
            head       = 0;
            held       = 0;
            overwrites = '0;
            failures   = 0;
            foreach (slot_type[k]) begin
                slot_type[k] = '0;
                slot_word[k] = '0;
            end
        endfunction

        function int unsigned ring_slot(int unsigned offset);
            return (head + offset) % RING_DEPTH;
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            failures++;
        endtask

        // apply one accepted word to the ring and queue the result it owes
        function void note_word(logic [ACTION_W-1:0] act, logic [TYPE_W-1:0] kind,
                                logic [WORD_W-1:0] word);
            t_ring_result r;
            int unsigned  idx;
            int unsigned  j;
            r.found   = 1'b0;
            r.payload = '0;
            case (act)
                ACT_PUSH: begin
                    if (kind != TYPE_NONE) begin
                        idx = ring_slot(held);
                        slot_type[idx] = kind;
                        slot_word[idx] = word;
                        if (held < RING_DEPTH) begin
                            held++;
                        end else begin
                            head = (head + 1) % RING_DEPTH;
                            if (overwrites != '1) overwrites++;
                        end
                    end
                end
                ACT_POP: begin
                    // oldest match leaves, later entries slide toward the head
                    for (idx = 0; idx < held && !r.found; idx++) begin
                        if (slot_type[ring_slot(idx)] == kind) begin
                            r.found   = 1'b1;
                            r.payload = slot_word[ring_slot(idx)];
                            for (j = idx; j + 1 < held; j++) begin
                                slot_type[ring_slot(j)] = slot_type[ring_slot(j + 1)];
                                slot_word[ring_slot(j)] = slot_word[ring_slot(j + 1)];
                            end
                            held--;
                            if (held == 0) head = 0;
                        end
                    end
                end
                ACT_QUERY: begin
                    for (idx = 0; idx < held; idx++)
                        if (slot_type[ring_slot(idx)] == kind) r.found = 1'b1;
                end
                default: ;
            endcase
            r.occupancy = held[OCC_W-1:0];
            r.overflow  = overwrites;
            owed_results.push_back(r);
        endfunction

        // compare one delivered result with the oldest owed one
        task check_word(logic found, logic [WORD_W-1:0] payload,
                        logic [OCC_W-1:0] occupancy, logic [WORD_W-1:0] overflow);
            t_ring_result r;
            if (owed_results.size() == 0) begin
                report("unexpected result word", payload, '0);
                return;
            end
            r = owed_results.pop_front();
            if (found !== r.found) report("found", found, r.found);
            if (payload !== r.payload) report("payload_out", payload, r.payload);
            if (occupancy !== r.occupancy) report("occupancy", occupancy, r.occupancy);
            if (overflow !== r.overflow) report("overflow_count", overflow, r.overflow);
        endtask

        task flag_leftovers();
            if (owed_results.size() != 0)
                report("results never delivered", owed_results.size(), 0);
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [ACTION_W-1:0] i_action = ACT_PUSH;
    logic [TYPE_W-1:0]   i_event_type = TYPE_NONE;
    logic [WORD_W-1:0]   i_payload = '0;
    logic                i_ready = 1'b1;
    logic                o_ready;
    logic                o_valid;
    logic                o_found;
    logic [WORD_W-1:0]   o_payload_out;
    logic [OCC_W-1:0]    o_occupancy;
    logic [WORD_W-1:0]   o_overflow_count;

    event_ring_tracker tracker = new();
    bit                quiet = 1'b0;

    typed_event_ring_selective_pop_unit #(
        .DEPTH         (RING_DEPTH),
        .PAYLOAD_WIDTH (WORD_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_event_type     (i_event_type),
        .i_payload        (i_payload),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_payload_out    (o_payload_out),
        .o_occupancy      (o_occupancy),
        .o_overflow_count (o_overflow_count)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one word, hold it until taken, then maybe idle
    task automatic send_word(logic [ACTION_W-1:0] act, logic [TYPE_W-1:0] kind,
                             logic [WORD_W-1:0] word);
        int unsigned gap;
        i_valid      <= 1'b1;
        i_action     <= act;
        i_event_type <= kind;
        i_payload    <= word;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_word(act, kind, word);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: check each taken word, stall at random
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                tracker.check_word(o_found, o_payload_out, o_occupancy, o_overflow_count);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                i_ready <= (stall_left == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // reset, directed words, random words, drain
    initial begin
        int unsigned      k;
        int unsigned      waited;
        int unsigned      push_pct;
        int unsigned      type_top;
        int unsigned      r;
        logic [TYPE_W-1:0] kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, dropped push and the unused code
        send_word(ACT_POP, 4'd5, 32'h0);
        send_word(ACT_QUERY, 4'd5, 32'h0);
        send_word(ACT_PUSH, TYPE_NONE, 32'hffff_ffff);
        send_word(ACT_UNUSED, 4'd15, 32'hffff_ffff);
        // pop from the middle, the head, then the last entry
        send_word(ACT_PUSH, 4'd15, 32'hffff_ffff);
        send_word(ACT_PUSH, 4'd1, 32'h0);
        send_word(ACT_PUSH, 4'd2, 32'ha5a5_5a5a);
        send_word(ACT_QUERY, 4'd15, 32'hffff_ffff);
        send_word(ACT_QUERY, TYPE_NONE, 32'h0);
        send_word(ACT_POP, TYPE_NONE, 32'h0);
        send_word(ACT_POP, 4'd1, 32'h0);
        send_word(ACT_POP, 4'd15, 32'h0);
        send_word(ACT_POP, 4'd2, 32'h0);
        send_word(ACT_QUERY, 4'd2, 32'h0);
        // fill past full so the oldest entries get overwritten
        for (k = 1; k <= RING_DEPTH + 2; k++)
            send_word(ACT_PUSH, k[TYPE_W-1:0], $urandom());
        send_word(ACT_POP, 4'd10, 32'h0);
        send_word(ACT_POP, 4'd3, 32'h0);
        send_word(ACT_QUERY, 4'd1, 32'h0);

        // random phases with shifting mix and type spread
        push_pct = 50;
        type_top = 4;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 100 == 0) begin
                quiet    = ($urandom_range(0, 3) == 0);
                push_pct = $urandom_range(30, 70);
                type_top = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(2, 5);
            end
            kind = ($urandom_range(0, 19) == 0) ? TYPE_NONE : $urandom_range(1, type_top);
            r = $urandom_range(0, 99);
            if (r < push_pct)
                send_word(ACT_PUSH, kind, $urandom());
            else if (r < 90)
                send_word(ACT_POP, kind, $urandom());
            else if (r < 97)
                send_word(ACT_QUERY, kind, $urandom());
            else
                send_word(ACT_UNUSED, kind, $urandom());
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        waited = 0;
        while (tracker.owed_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4 * RING_DEPTH + 8) @(posedge i_clk);
        tracker.flag_leftovers();
        if (tracker.failures == 0)
            $display("[typed_event_ring_selective_pop_unit] OK");
        else
            $display("[typed_event_ring_selective_pop_unit] ERROR");
        $finish;
    end

    // hard stop for a hung run
    initial begin
        #5_000_000;
        $display("[typed_event_ring_selective_pop_unit] ERROR");
        $finish;
    end

endmodule
